FILE: design/tcs_pkg.sv
`timescale 1ns / 1ps

package tcs_pkg;

   localparam int COORD_BITS  = 12;
   localparam int TEX_SIZE    = 64;
   localparam int TEX_BITS    = $clog2(TEX_SIZE);
   localparam int NUM_FACES   = 4;
   localparam int FACE_BITS   = $clog2(NUM_FACES);
   localparam int ADDR_BITS   = FACE_BITS + 2 * TEX_BITS;
   localparam int MEM_DEPTH   = NUM_FACES * TEX_SIZE * TEX_SIZE;
   localparam int FRAC_BITS   = 16;
   localparam int DIV_BITS    = TEX_BITS + FRAC_BITS + 1;
   localparam int STEP_BITS   = 24;
   localparam int POS_BITS    = 30;
   localparam int OFS_BITS    = COORD_BITS + 2;
   localparam int COLOR_BITS  = 24;
   localparam int CNT_BITS    = $clog2(DIV_BITS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int OP_BITS     = 2;
   localparam int RSP_BITS    = 2 * COORD_BITS + COLOR_BITS;

   localparam logic [CNT_BITS-1:0]   DIV_TOP          = CNT_BITS'(DIV_BITS - 1);
   localparam logic [COLOR_BITS-1:0] SHADE_MASK       = 24'h7F7F7F;
   localparam logic [COORD_BITS-1:0] SCREEN_H_RESET   = 12'd480;

   localparam logic [FACE_BITS-1:0] FACE_NORTH = 2'd0;
   localparam logic [FACE_BITS-1:0] FACE_SOUTH = 2'd1;
   localparam logic [FACE_BITS-1:0] FACE_WEST  = 2'd2;
   localparam logic [FACE_BITS-1:0] FACE_EAST  = 2'd3;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_EMIT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_MUL,
      FR_PUSH
   } front_state_type;

   // first field sits in the highest bits
   typedef struct packed {
      logic                  ray_dir_y_negative;
      logic                  hit_side;
      logic [COORD_BITS-1:0] line_height;
      logic [COORD_BITS-1:0] draw_end;
      logic [COORD_BITS-1:0] draw_start;
      logic [COORD_BITS-1:0] column_x;
      logic [COLOR_BITS-1:0] texel_value;
      logic [TEX_BITS-1:0]   tex_col;
      logic [TEX_BITS-1:0]   tex_row;
      logic [FACE_BITS-1:0]  face;
   } req_data_type;

   localparam int REQ_BITS = $bits(req_data_type);

   typedef struct packed {
      op_type                kind;
      logic [ADDR_BITS-1:0]  addr;
      logic [COLOR_BITS-1:0] texel;
      logic [STEP_BITS-1:0]  step;
      logic [POS_BITS-1:0]   pos;
      logic [FACE_BITS-1:0]  face;
      logic                  shaded;
      logic [COORD_BITS-1:0] column;
      logic [TEX_BITS-1:0]   tex_col;
      logic [COORD_BITS-1:0] row_start;
      logic [COORD_BITS-1:0] row_end;
   } cmd_type;

endpackage

FILE: design/texture_column_sampler_core.sv
`timescale 1ns / 1ps
// write and emit beats are taken one per cycle while the front is idle and the
// queue is not full; an emit passes the queue, the texture memory read and the
// output register before its pixel leaves; a column start holds the front through
// the bit-serial step divider, the position multiply and the push to the queue
// synchronous reset clears all control state and sets screen_height to 480;
// the texture memory is not cleared and holds garbage until written

module texture_column_sampler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // face, tex_row, tex_col, texel_value, column_x, draw_start, draw_end,
   // line_height, hit_side, ray_dir_y_negative
   input  logic [tcs_pkg::REQ_BITS-1:0]     req_tdata,
   // operation
   input  logic [tcs_pkg::OP_BITS-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_x, pixel_y, pixel_color
   output logic [tcs_pkg::RSP_BITS-1:0]     rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_wr_en,
   input  logic [tcs_pkg::COORD_BITS-1:0]   csr_wr_data
);

   logic [tcs_pkg::COORD_BITS-1:0] screen_height_ff;

   logic             q_push, q_pop, q_full, q_empty;
   tcs_pkg::cmd_type q_push_cmd, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff <= tcs_pkg::SCREEN_H_RESET;
      end else if (csr_wr_en) begin
         screen_height_ff <= csr_wr_data;
      end
   end

   tcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .screen_height (screen_height_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_push_cmd    (q_push_cmd)
   );

   tcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   tcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/tcs_front.sv
`timescale 1ns / 1ps

module tcs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tcs_pkg::REQ_BITS-1:0]     req_tdata,
   input  logic [tcs_pkg::OP_BITS-1:0]      req_tuser,
   input  logic [tcs_pkg::COORD_BITS-1:0]   screen_height,
   input  logic                             q_full,
   output logic                             q_push,
   output tcs_pkg::cmd_type                 q_push_cmd
);

   tcs_pkg::req_data_type req_data;
   tcs_pkg::op_type       op;
   logic                  accept;

   tcs_pkg::front_state_type state_ff, state_in;

   logic [tcs_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [tcs_pkg::COORD_BITS-1:0] rem_ff, rem_in;
   logic [tcs_pkg::DIV_BITS-1:0]   quot_ff, quot_in;
   logic [tcs_pkg::POS_BITS-1:0]   pos_ff, pos_in;

   logic [tcs_pkg::COORD_BITS-1:0] col_ff, ds_ff, de_ff, lh_ff;
   logic [tcs_pkg::TEX_BITS-1:0]   tcol_ff;
   logic [tcs_pkg::FACE_BITS-1:0]  face_ff;
   logic                           shaded_ff;
   logic [tcs_pkg::FACE_BITS-1:0]  face_pick;
   logic [tcs_pkg::COORD_BITS-1:0] lh_fix;

   logic [tcs_pkg::COORD_BITS:0]   trial;
   logic                           trial_ge;
   logic signed [tcs_pkg::OFS_BITS-1:0] offset;
   logic signed [tcs_pkg::OFS_BITS+tcs_pkg::DIV_BITS:0] product;

   assign req_data = tcs_pkg::req_data_type'(req_tdata);
   assign op       = tcs_pkg::op_type'(req_tuser);
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      if (req_data.hit_side == 1'b0) begin
         face_pick = req_data.ray_dir_y_negative ? tcs_pkg::FACE_WEST : tcs_pkg::FACE_EAST;
      end else begin
         face_pick = req_data.ray_dir_y_negative ? tcs_pkg::FACE_NORTH : tcs_pkg::FACE_SOUTH;
      end
      lh_fix = (req_data.line_height == '0) ? tcs_pkg::COORD_BITS'(1) : req_data.line_height;
   end

   // restoring division of TEX_SIZE << FRAC_BITS, one quotient bit a cycle
   always_comb begin
      trial    = {rem_ff, (cnt_ff == tcs_pkg::DIV_TOP)};
      trial_ge = trial >= {1'b0, lh_ff};
      rem_in   = trial_ge ? tcs_pkg::COORD_BITS'(trial - {1'b0, lh_ff})
                          : trial[tcs_pkg::COORD_BITS-1:0];
      quot_in  = {quot_ff[tcs_pkg::DIV_BITS-2:0], trial_ge};
      cnt_in   = cnt_ff - tcs_pkg::CNT_BITS'(1);
   end

   always_comb begin
      offset  = $signed({2'b00, ds_ff})
              - $signed({3'b000, screen_height[tcs_pkg::COORD_BITS-1:1]})
              + $signed({3'b000, lh_ff[tcs_pkg::COORD_BITS-1:1]});
      product = offset * $signed({1'b0, quot_ff});
      pos_in  = product[tcs_pkg::POS_BITS-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcs_pkg::FR_IDLE: begin
            if (accept && op == tcs_pkg::OP_START) begin
               state_in = tcs_pkg::FR_DIV;
            end
         end
         tcs_pkg::FR_DIV: begin
            if (cnt_ff == '0) begin
               state_in = tcs_pkg::FR_MUL;
            end
         end
         tcs_pkg::FR_MUL: begin
            state_in = tcs_pkg::FR_PUSH;
         end
         tcs_pkg::FR_PUSH: begin
            if (!q_full) begin
               state_in = tcs_pkg::FR_IDLE;
            end
         end
         default: state_in = tcs_pkg::FR_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      q_push     = 1'b0;
      q_push_cmd = '0;
      unique case (state_ff)
         tcs_pkg::FR_IDLE: begin
            req_tready         = !q_full;
            q_push             = req_tvalid && !q_full &&
                                 (op == tcs_pkg::OP_WRITE || op == tcs_pkg::OP_EMIT);
            q_push_cmd.kind    = op;
            q_push_cmd.addr    = {req_data.face, req_data.tex_row, req_data.tex_col};
            q_push_cmd.texel   = req_data.texel_value;
         end
         tcs_pkg::FR_PUSH: begin
            q_push               = !q_full;
            q_push_cmd.kind      = tcs_pkg::OP_START;
            q_push_cmd.step      = tcs_pkg::STEP_BITS'(quot_ff);
            q_push_cmd.pos       = pos_ff;
            q_push_cmd.face      = face_ff;
            q_push_cmd.shaded    = shaded_ff;
            q_push_cmd.column    = col_ff;
            q_push_cmd.tex_col   = tcol_ff;
            q_push_cmd.row_start = ds_ff;
            q_push_cmd.row_end   = de_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcs_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tcs_pkg::FR_IDLE && accept) begin
         col_ff    <= req_data.column_x;
         ds_ff     <= req_data.draw_start;
         de_ff     <= req_data.draw_end;
         lh_ff     <= lh_fix;
         tcol_ff   <= req_data.tex_col;
         face_ff   <= face_pick;
         shaded_ff <= req_data.hit_side;
         cnt_ff    <= tcs_pkg::DIV_TOP;
         rem_ff    <= '0;
         quot_ff   <= '0;
      end else if (state_ff == tcs_pkg::FR_DIV) begin
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (state_ff == tcs_pkg::FR_MUL) begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: design/tcs_queue.sv
`timescale 1ns / 1ps

module tcs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcs_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output tcs_pkg::cmd_type head
);

   tcs_pkg::cmd_type slot_ff [tcs_pkg::QUEUE_DEPTH];

   logic [tcs_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcs_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcs_pkg::QCNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == tcs_pkg::QCNT_BITS'(tcs_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tcs_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + tcs_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + tcs_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tcs_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + tcs_pkg::QCNT_BITS'(1)))
      else $error("queue count lost a push");
`endif

endmodule

FILE: design/tcs_back.sv
`timescale 1ns / 1ps

module tcs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  tcs_pkg::cmd_type               q_head,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tcs_pkg::RSP_BITS-1:0]   rsp_tdata,
   output logic                           rsp_tlast
);

   logic [tcs_pkg::COLOR_BITS-1:0] mem [tcs_pkg::MEM_DEPTH];

   logic [tcs_pkg::COORD_BITS-1:0] row_ff, row_in;
   logic [tcs_pkg::COORD_BITS-1:0] end_ff, end_in;
   logic [tcs_pkg::POS_BITS-1:0]   pos_ff, pos_in;
   logic [tcs_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic [tcs_pkg::COORD_BITS-1:0] column_ff, column_in;
   logic [tcs_pkg::TEX_BITS-1:0]   tcol_ff, tcol_in;
   logic [tcs_pkg::FACE_BITS-1:0]  face_ff, face_in;
   logic                           shaded_ff, shaded_in;
   logic                           active_ff, active_in;

   logic                           s1_valid_ff, s1_valid_in;
   logic [tcs_pkg::COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   logic                           s1_last_ff, s1_shaded_ff;
   logic [tcs_pkg::COLOR_BITS-1:0] rd_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tcs_pkg::RSP_BITS-1:0]   rsp_data_ff;
   logic                           rsp_last_ff;

   logic                           out_free;
   logic                           rd_en;
   logic                           last;
   logic [tcs_pkg::ADDR_BITS-1:0]  rd_addr;
   logic [tcs_pkg::COLOR_BITS-1:0] color;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = !q_empty &&
                     (q_head.kind != tcs_pkg::OP_EMIT || !active_ff || !s1_valid_ff || out_free);
   assign rd_en    = q_pop && q_head.kind == tcs_pkg::OP_EMIT && active_ff;
   assign rd_addr  = {face_ff, pos_ff[tcs_pkg::FRAC_BITS +: tcs_pkg::TEX_BITS], tcol_ff};
   assign last     = ({1'b0, row_ff} + (tcs_pkg::COORD_BITS+1)'(1)) >= {1'b0, end_ff};

   always_comb begin
      row_in    = row_ff;
      end_in    = end_ff;
      pos_in    = pos_ff;
      step_in   = step_ff;
      column_in = column_ff;
      tcol_in   = tcol_ff;
      face_in   = face_ff;
      shaded_in = shaded_ff;
      active_in = active_ff;
      if (q_pop && q_head.kind == tcs_pkg::OP_START) begin
         row_in    = q_head.row_start;
         end_in    = q_head.row_end;
         pos_in    = q_head.pos;
         step_in   = q_head.step;
         column_in = q_head.column;
         tcol_in   = q_head.tex_col;
         face_in   = q_head.face;
         shaded_in = q_head.shaded;
         active_in = q_head.row_start < q_head.row_end;
      end else if (rd_en) begin
         row_in    = row_ff + tcs_pkg::COORD_BITS'(1);
         pos_in    = pos_ff + tcs_pkg::POS_BITS'(step_ff);
         active_in = !last;
      end
   end

   always_comb begin
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      color = s1_shaded_ff ? ((rd_data_ff >> 1) & tcs_pkg::SHADE_MASK) : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         end_ff       <= '0;
         pos_ff       <= '0;
         step_ff      <= '0;
         column_ff    <= '0;
         tcol_ff      <= '0;
         face_ff      <= '0;
         shaded_ff    <= 1'b0;
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         end_ff       <= end_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         column_ff    <= column_in;
         tcol_ff      <= tcol_in;
         face_ff      <= face_in;
         shaded_ff    <= shaded_in;
         active_ff    <= active_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // texture store: one write or one read a cycle, read data registered
   always_ff @(posedge clock) begin
      if (q_pop && q_head.kind == tcs_pkg::OP_WRITE) begin
         mem[q_head.addr] <= q_head.texel;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_x_ff      <= column_ff;
         s1_y_ff      <= row_ff;
         s1_last_ff   <= last;
         s1_shaded_ff <= shaded_ff;
      end
      if (s1_valid_ff && out_free) begin
         rsp_data_ff <= {color, s1_y_ff, s1_x_ff};
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff)
      else $error("texel read issued but no pixel staged");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(rd_data_ff)))
      else $error("staged texel lost during output stall");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (!active_ff && !(q_pop && q_head.kind == tcs_pkg::OP_START)) |=> !$rose(s1_valid_ff))
      else $error("pixel staged without an active slice");
`endif

endmodule
